// File: design/weighted_rr_health_selector_top_assert.svh
// assertion macros shared by the selector top level
`ifndef WEIGHTED_RR_HEALTH_SELECTOR_TOP_ASSERT_SVH
`define WEIGHTED_RR_HEALTH_SELECTOR_TOP_ASSERT_SVH

// condition holds in the same cycle
`define WRR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wrr assertion failed");

// condition holds in the following cycle
`define WRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wrr assertion failed");

`endif

// File: design/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg
// Types, constants and helper functions of the weighted round-robin selector.
// ----------------------------------------------------------------------------
package wrr_pkg;

   localparam int ENDPOINTS  = 8;
   localparam int MAX_WEIGHT = 100;
   localparam int EP_W       = 3;
   localparam int CNT_W      = 4;
   localparam int WT_W       = 7;
   localparam int WTS_W      = 56;
   localparam int POS_W      = 10;
   localparam int CNTR_W     = 16;
   localparam int STEP_W     = 8;
   localparam int DIV_STEPS  = POS_W;

   localparam logic [CNT_W-1:0]  RESET_COUNT   = 4'd1;
   localparam logic [WTS_W-1:0]  RESET_WEIGHTS = 56'd567382630219905;
   localparam logic [STEP_W-1:0] RESET_STEP    = 8'd5;
   localparam logic [CNTR_W-1:0] RESET_CAP     = 16'd60;

   typedef enum logic [1:0] {
      REG_COUNT   = 2'd0,
      REG_WEIGHTS = 2'd1,
      REG_STEP    = 2'd2,
      REG_CAP     = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      CMD_SELECT  = 2'd0,
      CMD_FAIL    = 2'd1,
      CMD_SUCCESS = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      HOW_PREF     = 2'd0,
      HOW_ROTATION = 2'd1,
      HOW_FALLBACK = 2'd2
   } how_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FAIL,
      ST_DIV,
      ST_OWNER,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [WTS_W-1:0]  weights;
      logic [STEP_W-1:0] step;
      logic [CNTR_W-1:0] cap;
      logic              count_wr;
      logic [CNT_W-1:0]  count_new;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic fail_step;
      logic div_step;
      logic owner_step;
      logic pick;
   } ctrl_type;

   typedef struct packed {
      logic pref_hit;
      logic div_last;
      logic owner_last;
   } status_type;

   function automatic logic [WT_W-1:0] weight_of(logic [WTS_W-1:0] w, logic [EP_W-1:0] i);
      logic [WT_W-1:0] v;
      v = w[WT_W*i +: WT_W];
      if (v == '0) v = WT_W'(1);
      if (v > WT_W'(MAX_WEIGHT)) v = WT_W'(MAX_WEIGHT);
      return v;
   endfunction

   function automatic logic [POS_W-1:0] total_of(logic [WTS_W-1:0] w, logic [CNT_W-1:0] n);
      logic [POS_W-1:0] s;
      s = '0;
      for (int i = 0; i < ENDPOINTS; i++) begin
         if (CNT_W'(i) < n) s = s + POS_W'(weight_of(w, EP_W'(i)));
      end
      return s;
   endfunction

endpackage

// File: design/wrr_csr.sv
// ----------------------------------------------------------------------------
// wrr_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module wrr_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [4:0]              paddr,
   input  logic [63:0]             pwdata,
   output logic [63:0]             prdata,
   output logic                    pready,
   output wrr_pkg::cfg_type        cfg
);

   logic [wrr_pkg::CNT_W-1:0]  count_ff,   count_in;
   logic [wrr_pkg::WTS_W-1:0]  weights_ff, weights_in;
   logic [wrr_pkg::STEP_W-1:0] step_ff,    step_in;
   logic [wrr_pkg::CNTR_W-1:0] cap_ff,     cap_in;
   logic                       wr;
   wrr_pkg::reg_type           idx;
   logic [wrr_pkg::CNT_W-1:0]  cnt_clamped;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = wrr_pkg::reg_type'(paddr[4:3]);

   always_comb begin
      cnt_clamped = pwdata[wrr_pkg::CNT_W-1:0];
      if (cnt_clamped == '0) cnt_clamped = wrr_pkg::CNT_W'(1);
      if (cnt_clamped > wrr_pkg::CNT_W'(wrr_pkg::ENDPOINTS))
         cnt_clamped = wrr_pkg::CNT_W'(wrr_pkg::ENDPOINTS);
   end

   always_comb begin
      count_in   = count_ff;
      weights_in = weights_ff;
      step_in    = step_ff;
      cap_in     = cap_ff;
      if (wr) begin
         unique case (idx)
            wrr_pkg::REG_COUNT:   count_in   = cnt_clamped;
            wrr_pkg::REG_WEIGHTS: weights_in = pwdata[wrr_pkg::WTS_W-1:0];
            wrr_pkg::REG_STEP:    step_in    = pwdata[wrr_pkg::STEP_W-1:0];
            wrr_pkg::REG_CAP:     cap_in     = pwdata[wrr_pkg::CNTR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= wrr_pkg::RESET_COUNT;
         weights_ff <= wrr_pkg::RESET_WEIGHTS;
         step_ff    <= wrr_pkg::RESET_STEP;
         cap_ff     <= wrr_pkg::RESET_CAP;
      end else begin
         count_ff   <= count_in;
         weights_ff <= weights_in;
         step_ff    <= step_in;
         cap_ff     <= cap_in;
      end
   end

   always_comb begin
      unique case (idx)
         wrr_pkg::REG_COUNT:   prdata = 64'(count_ff);
         wrr_pkg::REG_WEIGHTS: prdata = 64'(weights_ff);
         wrr_pkg::REG_STEP:    prdata = 64'(step_ff);
         wrr_pkg::REG_CAP:     prdata = 64'(cap_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg.count     = count_ff;
   assign cfg.weights   = weights_ff;
   assign cfg.step      = step_ff;
   assign cfg.cap       = cap_ff;
   assign cfg.count_wr  = wr && (idx == wrr_pkg::REG_COUNT);
   assign cfg.count_new = cnt_clamped;

endmodule

// File: design/wrr_ctrl.sv
// ----------------------------------------------------------------------------
// wrr_ctrl
// Sequencer: steps the datapath through failure penalty and rotation search.
// ----------------------------------------------------------------------------
module wrr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_command,
   input  wrr_pkg::status_type  status,
   output wrr_pkg::ctrl_type    ctrl,
   output logic                 busy
);

   wrr_pkg::state_type state_ff, state_in;
   wrr_pkg::cmd_type   cmd;

   assign cmd = wrr_pkg::cmd_type'(req_command);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= wrr_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = 1'b1;
      unique case (state_ff)
         wrr_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load = 1'b1;
               if (cmd == wrr_pkg::CMD_FAIL) state_in = wrr_pkg::ST_FAIL;
               else if (cmd == wrr_pkg::CMD_SELECT && !status.pref_hit)
                  state_in = wrr_pkg::ST_DIV;
            end
         end
         wrr_pkg::ST_FAIL: begin
            ctrl.fail_step = 1'b1;
            state_in = wrr_pkg::ST_IDLE;
         end
         wrr_pkg::ST_DIV: begin
            ctrl.div_step = 1'b1;
            if (status.div_last) state_in = wrr_pkg::ST_OWNER;
         end
         wrr_pkg::ST_OWNER: begin
            ctrl.owner_step = 1'b1;
            if (status.owner_last) state_in = wrr_pkg::ST_PICK;
         end
         wrr_pkg::ST_PICK: begin
            ctrl.pick = 1'b1;
            state_in = wrr_pkg::ST_IDLE;
         end
         default: state_in = wrr_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: design/wrr_dp.sv
// ----------------------------------------------------------------------------
// wrr_dp
// Endpoint health state, rotation divider, owner search and result register.
// ----------------------------------------------------------------------------
module wrr_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  wrr_pkg::cfg_type               cfg,
   input  wrr_pkg::ctrl_type              ctrl,
   output wrr_pkg::status_type            status,
   input  logic [1:0]                     req_command,
   input  logic [wrr_pkg::EP_W-1:0]       req_endpoint,
   input  logic                           req_has_preferred,
   output logic                           rsp_valid,
   output logic [wrr_pkg::EP_W-1:0]       rsp_chosen,
   output logic [1:0]                     rsp_how_chosen
);

   localparam int N = wrr_pkg::ENDPOINTS;
   localparam int EW = wrr_pkg::EP_W;
   localparam int CW = wrr_pkg::CNT_W;
   localparam int PW = wrr_pkg::POS_W;
   localparam int RW = wrr_pkg::CNTR_W;

   logic [RW-1:0] fc_ff [N], fc_in [N];
   logic [RW-1:0] rem_ff[N], rem_in[N];
   logic [N-1:0]  pen_ff, pen_in;
   logic [PW-1:0] pos_ff, pos_in;

   logic [EW-1:0] ep_ff, ep_in;
   logic          ep_ok_ff, ep_ok_in;
   logic [PW-1:0] total_ff, total_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [PW-1:0] r_ff, r_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [EW-1:0] oi_ff, oi_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [EW-1:0] owner_ff, owner_in;
   logic          found_ff, found_in;
   logic [EW-1:0] best_ff, best_in;
   logic [RW-1:0] bestrem_ff, bestrem_in;
   logic          rv_ff, rv_in;
   logic [EW-1:0] chosen_ff, chosen_in;
   logic [1:0]    how_ff, how_in;

   logic [N-1:0]  bl;
   logic          pref_hit;
   logic          req_ok;
   wrr_pkg::cmd_type cmd;
   logic [PW:0]   sh;
   logic [PW-1:0] acc_next;
   logic [RW-1:0] fc_inc;
   logic [23:0]   prod;
   logic          rot_found;
   logic [EW-1:0] rot_pick;
   logic [CW-1:0] cand;
   logic [PW-1:0] idx_next;

   assign cmd    = wrr_pkg::cmd_type'(req_command);
   assign req_ok = {1'b0, req_endpoint} < cfg.count;

   always_comb begin
      for (int i = 0; i < N; i++) bl[i] = pen_ff[i] && (rem_ff[i] != '0);
   end

   assign pref_hit = req_has_preferred && req_ok && !bl[req_endpoint];

   assign status.pref_hit   = pref_hit;
   assign status.div_last   = (cnt_ff == '0);
   assign status.owner_last = ({1'b0, oi_ff} == cfg.count - CW'(1));

   // restoring division step for position mod total
   assign sh       = {r_ff, dvd_ff[PW-1]};
   assign acc_next = acc_ff + PW'(wrr_pkg::weight_of(cfg.weights, oi_ff));
   assign fc_inc   = (fc_ff[req_endpoint] == '1) ? fc_ff[req_endpoint]
                                                 : fc_ff[req_endpoint] + RW'(1);
   assign prod     = 24'(cfg.step) * 24'(fc_ff[ep_ff]);
   assign idx_next = (r_ff + PW'(1) == total_ff) ? '0 : r_ff + PW'(1);

   // first free endpoint in cyclic order from the slot owner
   always_comb begin
      rot_found = 1'b0;
      rot_pick  = '0;
      cand      = '0;
      for (int k = N - 1; k >= 0; k--) begin
         cand = {1'b0, owner_ff} + CW'(k);
         if (cand >= cfg.count) cand = cand - cfg.count;
         if (CW'(k) < cfg.count && !bl[cand[EW-1:0]]) begin
            rot_found = 1'b1;
            rot_pick  = cand[EW-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         fc_in[i]  = fc_ff[i];
         rem_in[i] = rem_ff[i];
      end
      pen_in     = pen_ff;
      pos_in     = pos_ff;
      ep_in      = ep_ff;
      ep_ok_in   = ep_ok_ff;
      total_in   = total_ff;
      dvd_in     = dvd_ff;
      r_in       = r_ff;
      cnt_in     = cnt_ff;
      oi_in      = oi_ff;
      acc_in     = acc_ff;
      owner_in   = owner_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bestrem_in = bestrem_ff;
      rv_in      = 1'b0;
      chosen_in  = chosen_ff;
      how_in     = how_ff;

      if (ctrl.load) begin
         ep_in      = req_endpoint;
         ep_ok_in   = req_ok;
         total_in   = wrr_pkg::total_of(cfg.weights, cfg.count);
         dvd_in     = pos_ff;
         r_in       = '0;
         cnt_in     = 4'(wrr_pkg::DIV_STEPS - 1);
         oi_in      = '0;
         acc_in     = '0;
         found_in   = 1'b0;
         best_in    = '0;
         bestrem_in = '1;
         case (cmd)
            wrr_pkg::CMD_TICK: begin
               for (int i = 0; i < N; i++)
                  if (rem_ff[i] != '0) rem_in[i] = rem_ff[i] - RW'(1);
            end
            wrr_pkg::CMD_FAIL: begin
               if (req_ok) begin
                  fc_in[req_endpoint] = fc_inc;
                  pen_in[req_endpoint] = 1'b1;
               end
            end
            wrr_pkg::CMD_SUCCESS: begin
               if (req_ok) begin
                  fc_in[req_endpoint]  = '0;
                  rem_in[req_endpoint] = '0;
                  pen_in[req_endpoint] = 1'b0;
               end
            end
            default: begin
               // end expired penalties
               for (int i = 0; i < N; i++) begin
                  if (pen_ff[i] && rem_ff[i] == '0) begin
                     pen_in[i] = 1'b0;
                     fc_in[i]  = '0;
                  end
               end
               if (pref_hit) begin
                  rv_in     = 1'b1;
                  chosen_in = req_endpoint;
                  how_in    = wrr_pkg::HOW_PREF;
               end
            end
         endcase
      end

      if (ctrl.fail_step && ep_ok_ff)
         rem_in[ep_ff] = (prod > 24'(cfg.cap)) ? cfg.cap : prod[RW-1:0];

      if (ctrl.div_step) begin
         r_in   = (sh >= {1'b0, total_ff}) ? PW'(sh - {1'b0, total_ff}) : sh[PW-1:0];
         dvd_in = {dvd_ff[PW-2:0], 1'b0};
         cnt_in = cnt_ff - 4'd1;
      end

      if (ctrl.owner_step) begin
         acc_in = acc_next;
         if (!found_ff && r_ff < acc_next) begin
            owner_in = oi_ff;
            found_in = 1'b1;
         end
         if (rem_ff[oi_ff] < bestrem_ff) begin
            best_in    = oi_ff;
            bestrem_in = rem_ff[oi_ff];
         end
         oi_in = oi_ff + EW'(1);
      end

      if (ctrl.pick) begin
         pos_in = idx_next;
         rv_in  = 1'b1;
         if (rot_found) begin
            chosen_in = rot_pick;
            how_in    = wrr_pkg::HOW_ROTATION;
         end else begin
            chosen_in       = best_ff;
            how_in          = wrr_pkg::HOW_FALLBACK;
            rem_in[best_ff] = '0;
            pen_in[best_ff] = 1'b0;
         end
      end

      // shrinking the endpoint set clears the entries left out
      if (cfg.count_wr) begin
         pos_in = '0;
         for (int i = 0; i < N; i++) begin
            if (CW'(i) >= cfg.count_new) begin
               fc_in[i]  = '0;
               rem_in[i] = '0;
               pen_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            fc_ff[i]  <= '0;
            rem_ff[i] <= '0;
         end
         pen_ff <= '0;
         pos_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < N; i++) begin
            fc_ff[i]  <= fc_in[i];
            rem_ff[i] <= rem_in[i];
         end
         pen_ff <= pen_in;
         pos_ff <= pos_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff      <= ep_in;
      ep_ok_ff   <= ep_ok_in;
      total_ff   <= total_in;
      dvd_ff     <= dvd_in;
      r_ff       <= r_in;
      cnt_ff     <= cnt_in;
      oi_ff      <= oi_in;
      acc_ff     <= acc_in;
      owner_ff   <= owner_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      bestrem_ff <= bestrem_in;
      chosen_ff  <= chosen_in;
      how_ff     <= how_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_chosen     = chosen_ff;
   assign rsp_how_chosen = how_ff;

endmodule

// File: design/weighted_rr_health_selector_top.sv
// ----------------------------------------------------------------------------
// weighted_rr_health_selector_top
// Weighted round-robin endpoint selector with failure backoff blacklist.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Tick and success
// reports are done once taken; a failure report, in range or not, then
// passes through the fail state for the penalty multiply. A select whose
// preferred endpoint is usable puts its result out in the cycle after it is
// taken. Any other select runs the bit-serial divider that reduces the
// rotation position by the total weight, then steps through the endpoints
// in use to find the slot owner and the earliest expiring endpoint, then
// picks. Each result is shown on rsp_chosen and rsp_how_chosen for one
// cycle with rsp_valid high and must be taken then; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "weighted_rr_health_selector_top_assert.svh"

module weighted_rr_health_selector_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  logic [wrr_pkg::EP_W-1:0]    req_endpoint,
   input  logic                        req_has_preferred,
   output logic                        rsp_valid,
   output logic [wrr_pkg::EP_W-1:0]    rsp_chosen,
   output logic [1:0]                  rsp_how_chosen,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [4:0]                  paddr,
   input  logic [63:0]                 pwdata,
   output logic [63:0]                 prdata,
   output logic                        pready
);

   wrr_pkg::cfg_type    cfg;
   wrr_pkg::ctrl_type   ctrl;
   wrr_pkg::status_type status;

   wrr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wrr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .ctrl        (ctrl),
      .busy        (busy)
   );

   wrr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .ctrl              (ctrl),
      .status            (status),
      .req_command       (req_command),
      .req_endpoint      (req_endpoint),
      .req_has_preferred (req_has_preferred),
      .rsp_valid         (rsp_valid),
      .rsp_chosen        (rsp_chosen),
      .rsp_how_chosen    (rsp_how_chosen)
   );

   // reports and ticks never produce a result
   `WRR_ASSERT_NEXT(a_no_rsp_after_report, clock, reset,
      start && !busy && (req_command != wrr_pkg::CMD_SELECT), !rsp_valid)

   // a preferred result follows its item directly
   `WRR_ASSERT_NOW(a_pref_direct, clock, reset,
      rsp_valid && (rsp_how_chosen == wrr_pkg::HOW_PREF), $past(start && !busy))

   // the chosen endpoint is always one in use
   `WRR_ASSERT_NOW(a_chosen_in_use, clock, reset,
      rsp_valid, {1'b0, rsp_chosen} < cfg.count)

endmodule
